@@ design/return_address_stack_recovery_assert.svh @@
// ----------------------------------------------------------------------------
// Return address stack recovery assertion macros
// Shared concurrent assertion forms for the return address stack design.
// ----------------------------------------------------------------------------
`ifndef RETURN_ADDRESS_STACK_RECOVERY_ASSERT_SVH
`define RETURN_ADDRESS_STACK_RECOVERY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RASR_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RASR_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/rasr_pkg.sv @@
// ----------------------------------------------------------------------------
// Return address stack recovery package
// Field widths, command and mode codes, and the word types of the channels.
// ----------------------------------------------------------------------------
package rasr_pkg;

	localparam int ADDR_W = 64;
	localparam int CMD_W  = 3;
	localparam int ID_W   = 5;
	localparam int KIND_W = 2;
	localparam int MODE_W = 2;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [CMD_W-1:0] CMD_SPEC    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SAVE    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RESTORE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_LOG     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_MISP    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_FLUSH   = 3'd5;

	localparam logic [MODE_W-1:0] MODE_PTR     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CONTENT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WALK    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RSVD    = 2'd3;

	localparam logic [KIND_W-1:0] KIND_OTHER = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DCALL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ICALL = 2'd2;
	localparam logic [KIND_W-1:0] KIND_RET   = 2'd3;

	// Register select taken from the word address bit of paddr.
	localparam logic REG_MODE = 1'b0;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic              do_pop;
		logic              do_push;
		logic [ADDR_W-1:0] push_address;
		logic [ID_W-1:0]   log_id;
		logic [KIND_W-1:0] branch_kind;
	} item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] top_target;
		logic              check_failed;
	} result_t;

	typedef struct packed {
		logic busy;
		logic recovering;
	} ctrl_stat_t;

endpackage

@@ design/rasr_if.sv @@
// ----------------------------------------------------------------------------
// Return address stack recovery channel interfaces
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface rasr_req_if;
	logic                              valid;
	logic                              ready;
	logic [rasr_pkg::CMD_W-1:0]        cmd;
	logic                              do_pop;
	logic                              do_push;
	logic [rasr_pkg::ADDR_W-1:0]       push_address;
	logic [rasr_pkg::ID_W-1:0]         log_id;
	logic [rasr_pkg::KIND_W-1:0]       branch_kind;

	modport source (
		output valid, cmd, do_pop, do_push, push_address, log_id, branch_kind,
		input  ready
	);
	modport sink (
		input  valid, cmd, do_pop, do_push, push_address, log_id, branch_kind,
		output ready
	);
endinterface

interface rasr_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [rasr_pkg::ADDR_W-1:0] top_target;
	logic                        check_failed;

	modport source (
		output valid, top_target, check_failed,
		input  ready
	);
	modport sink (
		input  valid, top_target, check_failed,
		output ready
	);
endinterface

@@ design/rasr_ram.sv @@
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module rasr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/rasr_cfg.sv @@
// ----------------------------------------------------------------------------
// Return address stack recovery register file
// APB-style access to the recovery mode register.
// ----------------------------------------------------------------------------
module rasr_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rasr_pkg::APB_AW-1:0]   paddr,
	input  logic [rasr_pkg::APB_DW-1:0]   pwdata,
	output logic [rasr_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output logic [rasr_pkg::MODE_W-1:0]   recovery_mode
);

	logic [rasr_pkg::MODE_W-1:0] mode_q;
	logic                        sel_mode;

	assign sel_mode = (paddr[2] == rasr_pkg::REG_MODE);
	assign pready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= rasr_pkg::MODE_PTR;
		end else if (psel && penable && pwrite && sel_mode) begin
			mode_q <= pwdata[rasr_pkg::MODE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_mode) begin
			prdata = {{(rasr_pkg::APB_DW - rasr_pkg::MODE_W){1'b0}}, mode_q};
		end
	end

	assign recovery_mode = mode_q;

endmodule

@@ design/rasr_ctrl.sv @@
// ----------------------------------------------------------------------------
// Return address stack recovery controller
// Sequencer that reads, modifies and writes back the stack and log memories.
// ----------------------------------------------------------------------------
module rasr_ctrl #(
	parameter int STACK_DEPTH = 16,
	parameter int LOG_DEPTH   = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [rasr_pkg::MODE_W-1:0] mode,
	input  logic                        item_vld,
	output logic                        item_rdy,
	input  rasr_pkg::item_t             item,
	output logic                        res_vld,
	input  logic                        res_room,
	output rasr_pkg::result_t           res,
	output rasr_pkg::ctrl_stat_t        stat
);

	localparam int PW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int TW     = $clog2(LOG_DEPTH);
	localparam int AW     = rasr_pkg::ADDR_W;
	localparam int RET_B  = AW;
	localparam int CALL_B = AW + 1;
	localparam int LW     = PW + AW + 2;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_LOGRD = 3'd2;
	localparam logic [2:0] S_APPLY = 3'd3;
	localparam logic [2:0] S_READ  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(STACK_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PW-1:0] ptr_prev(input logic [PW-1:0] p);
		return (p == '0) ? PW'(STACK_DEPTH - 1) : p - 1'b1;
	endfunction

	function automatic logic [PW-1:0] ptr_clamp(input logic [PW-1:0] p);
		return (32'(p) < STACK_DEPTH) ? p : '0;
	endfunction

	function automatic logic [TW-1:0] tail_next(input logic [TW-1:0] t);
		return (t == TW'(LOG_DEPTH - 1)) ? '0 : t + 1'b1;
	endfunction

	function automatic logic [TW-1:0] tail_prev(input logic [TW-1:0] t);
		return (t == '0) ? TW'(LOG_DEPTH - 1) : t - 1'b1;
	endfunction

	logic [2:0]             state_q, state_d;
	rasr_pkg::item_t        item_q;
	logic [PW-1:0]          top_q, top_d;
	logic [PW-1:0]          sptr_q, sptr_d;
	logic [AW-1:0]          scont_q, scont_d;
	logic [TW-1:0]          tail_q, tail_d;
	logic                   fail_q, fail_d;
	logic [STACK_DEPTH-1:0] vld_q;
	logic                   stk_rvld_q;

	logic          stk_we, stk_re;
	logic [PW-1:0] stk_waddr, stk_raddr;
	logic [AW-1:0] stk_wdata, stk_rdata;
	logic          log_we, log_re;
	logic [TW-1:0] log_waddr, log_raddr;
	logic [LW-1:0] log_wdata, log_rdata;

	logic          id_bad;
	logic [TW-1:0] id_idx;
	logic [PW-1:0] pop_ptr, push_ptr;
	logic [PW-1:0] lptr, adj_ptr;
	logic          walk_done;
	logic          kind_call, kind_ret;
	logic [AW-1:0] top_data;

	rasr_ram #(.WIDTH(AW), .DEPTH(STACK_DEPTH)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	rasr_ram #(.WIDTH(LW), .DEPTH(LOG_DEPTH)) u_log_ram (
		.clk   (clk),
		.we    (log_we),
		.waddr (log_waddr),
		.wdata (log_wdata),
		.re    (log_re),
		.raddr (log_raddr),
		.rdata (log_rdata)
	);

	assign id_bad    = 32'(item_q.log_id) >= LOG_DEPTH;
	assign id_idx    = TW'(item_q.log_id);
	assign pop_ptr   = item_q.do_pop ? ptr_prev(top_q) : top_q;
	assign push_ptr  = item_q.do_push ? ptr_next(pop_ptr) : pop_ptr;
	assign kind_call = (item_q.branch_kind == rasr_pkg::KIND_DCALL) ||
	                   (item_q.branch_kind == rasr_pkg::KIND_ICALL);
	assign kind_ret  = (item_q.branch_kind == rasr_pkg::KIND_RET);

	// A mispredicted call re-pushes its slot, a mispredicted return pops.
	always_comb begin
		lptr    = ptr_clamp(log_rdata[LW-1 -: PW]);
		adj_ptr = lptr;
		if (log_rdata[CALL_B]) begin
			adj_ptr = ptr_next(adj_ptr);
		end
		if (log_rdata[RET_B]) begin
			adj_ptr = ptr_prev(adj_ptr);
		end
	end

	assign walk_done = (mode != rasr_pkg::MODE_WALK) || (tail_q == id_idx);
	assign top_data  = stk_rvld_q ? stk_rdata : '0;

	assign item_rdy         = (state_q == S_IDLE);
	assign res_vld          = (state_q == S_DONE);
	assign res.top_target   = top_data;
	assign res.check_failed = fail_q ||
	                          ((item_q.cmd == rasr_pkg::CMD_RESTORE) && (top_data != scont_q));
	assign stat.busy        = (state_q != S_IDLE);
	assign stat.recovering  = (state_q == S_LOGRD) || (state_q == S_APPLY);

	always_comb begin
		state_d   = state_q;
		top_d     = top_q;
		sptr_d    = sptr_q;
		scont_d   = scont_q;
		tail_d    = tail_q;
		fail_d    = fail_q;
		stk_we    = 1'b0;
		stk_waddr = push_ptr;
		stk_wdata = item_q.push_address;
		stk_re    = 1'b0;
		stk_raddr = top_q;
		log_we    = 1'b0;
		log_waddr = id_idx;
		log_wdata = {sptr_q, kind_call, kind_ret, scont_q};
		log_re    = 1'b0;
		log_raddr = id_idx;
		case (state_q)
			S_IDLE: begin
				if (item_vld) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				fail_d  = 1'b0;
				state_d = S_READ;
				case (item_q.cmd)
					rasr_pkg::CMD_SPEC: begin
						fail_d = item_q.do_pop && item_q.do_push;
						top_d  = push_ptr;
						stk_we = item_q.do_push;
					end
					rasr_pkg::CMD_SAVE: begin
						sptr_d = top_q;
					end
					rasr_pkg::CMD_RESTORE: begin
						top_d = ptr_clamp(sptr_q);
					end
					rasr_pkg::CMD_LOG: begin
						if (id_bad) begin
							fail_d = 1'b1;
						end else begin
							log_we = 1'b1;
							fail_d = (tail_q != id_idx);
							tail_d = tail_next(tail_q);
						end
					end
					rasr_pkg::CMD_MISP, rasr_pkg::CMD_FLUSH: begin
						if (id_bad) begin
							fail_d = 1'b1;
						end else begin
							fail_d  = (mode == rasr_pkg::MODE_RSVD);
							state_d = S_LOGRD;
						end
					end
					default: begin
					end
				endcase
			end
			S_LOGRD: begin
				log_re = 1'b1;
				if (mode == rasr_pkg::MODE_WALK) begin
					log_raddr = tail_prev(tail_q);
				end
				tail_d  = log_raddr;
				state_d = S_APPLY;
			end
			S_APPLY: begin
				stk_waddr = lptr;
				stk_wdata = log_rdata[AW-1:0];
				stk_we    = (mode == rasr_pkg::MODE_CONTENT) || (mode == rasr_pkg::MODE_WALK);
				top_d     = lptr;
				if (walk_done) begin
					state_d = S_READ;
					if (item_q.cmd == rasr_pkg::CMD_MISP) begin
						top_d  = adj_ptr;
						tail_d = tail_next(tail_q);
					end
				end else begin
					state_d = S_LOGRD;
				end
			end
			S_READ: begin
				stk_re  = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (item_q.cmd == rasr_pkg::CMD_SAVE) begin
					scont_d = top_data;
				end
				if (res_room) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			top_q      <= '0;
			sptr_q     <= '0;
			scont_q    <= '0;
			tail_q     <= '0;
			fail_q     <= 1'b0;
			vld_q      <= '0;
			stk_rvld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			top_q   <= top_d;
			sptr_q  <= sptr_d;
			scont_q <= scont_d;
			tail_q  <= tail_d;
			fail_q  <= fail_d;
			if (stk_we) begin
				vld_q[stk_waddr] <= 1'b1;
			end
			if (stk_re) begin
				stk_rvld_q <= vld_q[stk_raddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_vld && item_rdy) begin
			item_q <= item;
		end
	end

endmodule

@@ design/return_address_stack_recovery.sv @@
// ----------------------------------------------------------------------------
// Return address stack with checkpoint recovery
// Circular return address stack and branch checkpoint log for a front end.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake       Word
//  req      sink       valid / ready   cmd, do_pop, do_push, push_address,
//                                      log_id, branch_kind
//  rsp      source     valid / ready   top_target, check_failed
//  apb      slave      psel / penable  recovery_mode at byte address 0
//
// A word passes through the idle, exec, read and done states from one
// acceptance to the next; mispredict and flush add a log read and an apply
// state for each log slot read, one slot in the pointer modes and every slot
// from the tail back to log_id in walk mode. Both memories have a registered
// read. Reset needs no clearing pass: per-entry valid bits make unwritten
// stack entries read as zero. A result waits in the output register while rsp
// is stalled, and the next word is still accepted.
//
`include "return_address_stack_recovery_assert.svh"

module return_address_stack_recovery #(
	parameter int STACK_DEPTH = 16,
	parameter int LOG_DEPTH   = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rasr_pkg::APB_AW-1:0] paddr,
	input  logic [rasr_pkg::APB_DW-1:0] pwdata,
	output logic [rasr_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	rasr_req_if.sink                    req,
	rasr_rsp_if.source                  rsp
);

	logic [rasr_pkg::MODE_W-1:0] recovery_mode;
	rasr_pkg::item_t             item;
	rasr_pkg::result_t           res;
	rasr_pkg::result_t           out_q;
	rasr_pkg::ctrl_stat_t        stat;
	logic                        res_vld;
	logic                        res_room;
	logic                        out_vld_q;

	rasr_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.recovery_mode (recovery_mode)
	);

	assign item.cmd          = req.cmd;
	assign item.do_pop       = req.do_pop;
	assign item.do_push      = req.do_push;
	assign item.push_address = req.push_address;
	assign item.log_id       = req.log_id;
	assign item.branch_kind  = req.branch_kind;

	rasr_ctrl #(.STACK_DEPTH(STACK_DEPTH), .LOG_DEPTH(LOG_DEPTH)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (recovery_mode),
		.item_vld (req.valid),
		.item_rdy (req.ready),
		.item     (item),
		.res_vld  (res_vld),
		.res_room (res_room),
		.res      (res),
		.stat     (stat)
	);

	assign res_room = !out_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_vld && res_room) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld && res_room) begin
			out_q <= res;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.top_target   = out_q.top_target;
	assign rsp.check_failed = out_q.check_failed;

	`RASR_ASSERT_NXT(a_one_word, clk, arst_n, req.valid && req.ready, !req.ready, "word overlap")
	`RASR_ASSERT_NXT(a_hold, clk, arst_n, res_vld && !res_room, res_vld && $stable(res), "stall lost")
	`RASR_ASSERT_IMP(a_walk, clk, arst_n, stat.recovering, !res_vld && stat.busy, "result in walk")

endmodule

@@ tb/sv/return_address_stack_recovery_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Return address stack recovery testbench
// Drives command words into the stack under all four recovery modes, with
// random stalls on both channels. A local copy of the stack and checkpoint
// log predicts every result word, which is checked field by field.
// ----------------------------------------------------------------------------
module return_address_stack_recovery_test;

	localparam int LOG_SLOTS = 32;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam logic [rasr_pkg::CMD_W-1:0] CMD_UNUSED6 = 3'd6;
	localparam logic [rasr_pkg::CMD_W-1:0] CMD_UNUSED7 = 3'd7;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [rasr_pkg::APB_AW-1:0] paddr;
	logic [rasr_pkg::APB_DW-1:0] pwdata, prdata;

	rasr_req_if req_bus();
	rasr_rsp_if rsp_bus();

	return_address_stack_recovery uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req(req_bus), .rsp(rsp_bus)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	rasr_pkg::item_t pending_words[$];
	rasr_pkg::result_t expected_tops[$];

	// Predicted stack and checkpoint log.
	logic [rasr_pkg::ADDR_W-1:0] ras_mem[16];
	logic [3:0] ras_top, saved_top;
	logic [rasr_pkg::ADDR_W-1:0] saved_tgt;
	logic [3:0] ckpt_top[LOG_SLOTS];
	logic [rasr_pkg::ADDR_W-1:0] ckpt_tgt[LOG_SLOTS];
	logic ckpt_call[LOG_SLOTS];
	logic ckpt_ret[LOG_SLOTS];
	logic [rasr_pkg::ID_W-1:0] ckpt_tail;
	logic [rasr_pkg::MODE_W-1:0] ras_mode;

	// Log slots written so far and the tail, as seen by the word generator.
	bit plan_written[LOG_SLOTS];
	logic [rasr_pkg::ID_W-1:0] plan_tail;

	int send_idle, rcv_idle;
	int hold_asked, hold_taken, hold_left;
	int mismatches, words_in, results_out, flagged, recoveries, idle_cycles;

	function automatic logic rewind_from(input logic [rasr_pkg::ID_W-1:0] slot);
		logic flag;
		flag = 1'b0;
		if (ras_mode == rasr_pkg::MODE_CONTENT) begin
			ras_top = ckpt_top[slot];
			ras_mem[ras_top] = ckpt_tgt[slot];
			ckpt_tail = slot;
		end else if (ras_mode == rasr_pkg::MODE_WALK) begin
			do begin
				ckpt_tail = ckpt_tail - 1'b1;
				ras_top = ckpt_top[ckpt_tail];
				ras_mem[ras_top] = ckpt_tgt[ckpt_tail];
			end while (ckpt_tail != slot);
		end else begin
			ras_top = ckpt_top[slot];
			ckpt_tail = slot;
			flag = (ras_mode != rasr_pkg::MODE_PTR);
		end
		return flag;
	endfunction

	function automatic rasr_pkg::result_t predict_top(input rasr_pkg::item_t w);
		rasr_pkg::result_t r;
		logic flag;
		flag = 1'b0;
		case (w.cmd)
			rasr_pkg::CMD_SPEC: begin
				if (w.do_pop && w.do_push)
					flag = 1'b1;
				if (w.do_pop)
					ras_top = ras_top - 1'b1;
				if (w.do_push) begin
					ras_top = ras_top + 1'b1;
					ras_mem[ras_top] = w.push_address;
				end
			end
			rasr_pkg::CMD_SAVE: begin
				saved_top = ras_top;
				saved_tgt = ras_mem[ras_top];
			end
			rasr_pkg::CMD_RESTORE: begin
				ras_top = saved_top;
				flag = (ras_mem[ras_top] != saved_tgt);
			end
			rasr_pkg::CMD_LOG: begin
				ckpt_top[w.log_id] = saved_top;
				ckpt_tgt[w.log_id] = saved_tgt;
				ckpt_call[w.log_id] = (w.branch_kind == rasr_pkg::KIND_DCALL) ||
					(w.branch_kind == rasr_pkg::KIND_ICALL);
				ckpt_ret[w.log_id] = (w.branch_kind == rasr_pkg::KIND_RET);
				flag = (ckpt_tail != w.log_id);
				ckpt_tail = ckpt_tail + 1'b1;
			end
			rasr_pkg::CMD_MISP: begin
				recoveries++;
				flag = rewind_from(w.log_id);
				if (ckpt_call[w.log_id])
					ras_top = ras_top + 1'b1;
				if (ckpt_ret[w.log_id])
					ras_top = ras_top - 1'b1;
				ckpt_tail = ckpt_tail + 1'b1;
			end
			rasr_pkg::CMD_FLUSH: begin
				recoveries++;
				flag = rewind_from(w.log_id);
			end
			default: begin
			end
		endcase
		r.top_target = ras_mem[ras_top];
		r.check_failed = flag;
		return r;
	endfunction

	function automatic rasr_pkg::item_t mk(input logic [rasr_pkg::CMD_W-1:0] cmd,
			input logic pop, input logic push,
			input logic [rasr_pkg::ADDR_W-1:0] addr,
			input logic [rasr_pkg::ID_W-1:0] id,
			input logic [rasr_pkg::KIND_W-1:0] kind);
		rasr_pkg::item_t w;
		w.cmd = cmd;
		w.do_pop = pop;
		w.do_push = push;
		w.push_address = addr;
		w.log_id = id;
		w.branch_kind = kind;
		return w;
	endfunction

	task automatic add_word(input rasr_pkg::item_t w);
		case (w.cmd)
			rasr_pkg::CMD_LOG: begin
				plan_written[w.log_id] = 1'b1;
				plan_tail = plan_tail + 1'b1;
			end
			rasr_pkg::CMD_MISP: plan_tail = w.log_id + 1'b1;
			rasr_pkg::CMD_FLUSH: plan_tail = w.log_id;
			default: begin
			end
		endcase
		pending_words.push_back(w);
	endtask

	// Picks a slot that a recovery may read in the given mode; a walk must
	// pass over written slots only.
	function automatic logic [rasr_pkg::ID_W-1:0] pick_slot(
			input logic [rasr_pkg::MODE_W-1:0] mode, output bit ok);
		int run, d;
		logic [rasr_pkg::ID_W-1:0] t, pick;
		ok = 1'b0;
		pick = '0;
		if (mode == rasr_pkg::MODE_WALK) begin
			t = plan_tail;
			run = 0;
			while (run < LOG_SLOTS) begin
				t = t - 1'b1;
				if (!plan_written[t])
					break;
				run++;
			end
			if (run > 0) begin
				ok = 1'b1;
				if ($urandom_range(9) == 0)
					d = $urandom_range(run, 1);
				else
					d = $urandom_range((run < 4) ? run : 4, 1);
				pick = plan_tail - d[rasr_pkg::ID_W-1:0];
			end
		end else begin
			for (int i = 0; i < 12 && !ok; i++) begin
				if (i < 4)
					t = plan_tail - 1'b1 - rasr_pkg::ID_W'($urandom_range(7));
				else
					t = rasr_pkg::ID_W'($urandom_range(LOG_SLOTS - 1));
				if (plan_written[t]) begin
					ok = 1'b1;
					pick = t;
				end
			end
		end
		return pick;
	endfunction

	task automatic add_random_words(input int count,
			input logic [rasr_pkg::MODE_W-1:0] mode);
		rasr_pkg::item_t w;
		int r, sent;
		bit ok;
		sent = 0;
		while (sent < count) begin
			w = mk(rasr_pkg::CMD_SPEC, 1'($urandom_range(1)), 1'($urandom_range(1)),
				{$urandom, $urandom}, rasr_pkg::ID_W'($urandom_range(LOG_SLOTS - 1)),
				rasr_pkg::KIND_W'($urandom_range(3)));
			r = $urandom_range(99);
			if (r < 32) begin
				if (w.do_pop && w.do_push && $urandom_range(9) != 0)
					w.do_pop = 1'b0;
			end else if (r < 44) begin
				w.cmd = rasr_pkg::CMD_SAVE;
			end else if (r < 52) begin
				w.cmd = rasr_pkg::CMD_RESTORE;
			end else if (r < 72) begin
				w.cmd = rasr_pkg::CMD_LOG;
				if ($urandom_range(9) != 0)
					w.log_id = plan_tail;
			end else if (r < 94) begin
				w.cmd = (r < 85) ? rasr_pkg::CMD_MISP : rasr_pkg::CMD_FLUSH;
				w.log_id = pick_slot(mode, ok);
				if (!ok) begin
					w.cmd = rasr_pkg::CMD_LOG;
					w.log_id = plan_tail;
				end
			end else begin
				w.cmd = (r < 97) ? CMD_UNUSED6 : CMD_UNUSED7;
			end
			sent++;
			add_word(w);
		end
	endtask

	task automatic wait_drained;
		do begin
			@(posedge clk);
			#1;
		end while (pending_words.size() != 0 || req_bus.valid || expected_tops.size() != 0);
	endtask

	task automatic apb_access(input logic wr, input logic [rasr_pkg::APB_DW-1:0] data,
			output logic [rasr_pkg::APB_DW-1:0] rd);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {rasr_pkg::REG_MODE, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic program_mode(input logic [rasr_pkg::MODE_W-1:0] mode);
		logic [rasr_pkg::APB_DW-1:0] rd;
		repeat (8) @(posedge clk);
		apb_access(1'b1, rasr_pkg::APB_DW'(mode), rd);
		ras_mode = mode;
		apb_access(1'b0, '0, rd);
		if (rd[rasr_pkg::MODE_W-1:0] != mode) begin
			mismatches++;
			$display("%0t: recovery_mode readback mismatch: expected %0d, got %0d",
				$time, mode, rd[rasr_pkg::MODE_W-1:0]);
		end
	endtask

	always @(posedge clk) begin : driver
		rasr_pkg::item_t nxt;
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
		end else if (!req_bus.valid || req_bus.ready) begin
			if (pending_words.size() != 0 && $urandom_range(99) >= send_idle) begin
				nxt = pending_words.pop_front();
				req_bus.valid <= 1'b1;
				req_bus.cmd <= nxt.cmd;
				req_bus.do_pop <= nxt.do_pop;
				req_bus.do_push <= nxt.do_push;
				req_bus.push_address <= nxt.push_address;
				req_bus.log_id <= nxt.log_id;
				req_bus.branch_kind <= nxt.branch_kind;
			end else begin
				req_bus.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : receiver
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_bus.ready <= 1'b0;
		end else if (hold_taken != hold_asked) begin
			hold_taken <= hold_taken + 1;
			hold_left <= HOLD_CYCLES;
			rsp_bus.ready <= 1'b0;
		end else begin
			rsp_bus.ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	always @(posedge clk) begin : monitor
		rasr_pkg::item_t seen;
		rasr_pkg::result_t want;
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				results_out++;
				if (rsp_bus.check_failed)
					flagged++;
				if (expected_tops.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result word: top_target %h check_failed %b",
						$time, rsp_bus.top_target, rsp_bus.check_failed);
				end else begin
					want = expected_tops.pop_front();
					if (rsp_bus.top_target !== want.top_target) begin
						mismatches++;
						$display("%0t: top_target mismatch: expected %h, got %h",
							$time, want.top_target, rsp_bus.top_target);
					end
					if (rsp_bus.check_failed !== want.check_failed) begin
						mismatches++;
						$display("%0t: check_failed mismatch: expected %b, got %b",
							$time, want.check_failed, rsp_bus.check_failed);
					end
				end
			end
			if (req_bus.valid && req_bus.ready) begin
				words_in++;
				seen.cmd = req_bus.cmd;
				seen.do_pop = req_bus.do_pop;
				seen.do_push = req_bus.do_push;
				seen.push_address = req_bus.push_address;
				seen.log_id = req_bus.log_id;
				seen.branch_kind = req_bus.branch_kind;
				expected_tops.push_back(predict_top(seen));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, idle_cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		logic [rasr_pkg::MODE_W-1:0] phase_modes[9];
		phase_modes = '{rasr_pkg::MODE_CONTENT, rasr_pkg::MODE_WALK, rasr_pkg::MODE_PTR,
			rasr_pkg::MODE_WALK, rasr_pkg::MODE_RSVD, rasr_pkg::MODE_CONTENT,
			rasr_pkg::MODE_PTR, rasr_pkg::MODE_WALK, rasr_pkg::MODE_CONTENT};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_bus.valid = 1'b0;
		req_bus.cmd = rasr_pkg::CMD_SPEC;
		req_bus.do_pop = 1'b0;
		req_bus.do_push = 1'b0;
		req_bus.push_address = '0;
		req_bus.log_id = '0;
		req_bus.branch_kind = rasr_pkg::KIND_OTHER;
		rsp_bus.ready = 1'b0;
		send_idle = 24;
		rcv_idle = 86;
		hold_asked = 0;
		hold_taken = 0;
		hold_left = 0;
		mismatches = 0;
		words_in = 0;
		results_out = 0;
		flagged = 0;
		recoveries = 0;
		idle_cycles = 0;
		foreach (ras_mem[i])
			ras_mem[i] = '0;
		foreach (ckpt_top[i]) begin
			ckpt_top[i] = '0;
			ckpt_tgt[i] = '0;
			ckpt_call[i] = 1'b0;
			ckpt_ret[i] = 1'b0;
			plan_written[i] = 1'b0;
		end
		ras_top = '0;
		saved_top = '0;
		saved_tgt = '0;
		ckpt_tail = '0;
		ras_mode = rasr_pkg::MODE_PTR;
		plan_tail = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		program_mode(rasr_pkg::MODE_PTR);

		add_word(mk(rasr_pkg::CMD_SPEC, 1'b1, 1'b0, '0, '0, rasr_pkg::KIND_OTHER));
		add_word(mk(rasr_pkg::CMD_SPEC, 1'b0, 1'b1, '1, '0, rasr_pkg::KIND_OTHER));
		add_word(mk(rasr_pkg::CMD_SPEC, 1'b0, 1'b1, '0, '0, rasr_pkg::KIND_OTHER));
		add_word(mk(rasr_pkg::CMD_SPEC, 1'b1, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, '0,
			rasr_pkg::KIND_OTHER));
		add_word(mk(rasr_pkg::CMD_SAVE, 1'b0, 1'b0, '0, '0, rasr_pkg::KIND_OTHER));
		add_word(mk(rasr_pkg::CMD_LOG, 1'b0, 1'b0, '0, 5'd0, rasr_pkg::KIND_DCALL));
		add_word(mk(rasr_pkg::CMD_SPEC, 1'b0, 1'b1, 64'h5555_5555_5555_5555, '0,
			rasr_pkg::KIND_OTHER));
		add_word(mk(rasr_pkg::CMD_SAVE, 1'b0, 1'b0, '0, '0, rasr_pkg::KIND_OTHER));
		add_word(mk(rasr_pkg::CMD_LOG, 1'b0, 1'b0, '0, 5'd1, rasr_pkg::KIND_RET));
		add_word(mk(rasr_pkg::CMD_SPEC, 1'b1, 1'b0, '0, '0, rasr_pkg::KIND_OTHER));
		add_word(mk(rasr_pkg::CMD_SPEC, 1'b0, 1'b1, 64'h0123_4567_89AB_CDEF, '0,
			rasr_pkg::KIND_OTHER));
		add_word(mk(rasr_pkg::CMD_RESTORE, 1'b0, 1'b0, '0, '0, rasr_pkg::KIND_OTHER));
		add_word(mk(rasr_pkg::CMD_SAVE, 1'b0, 1'b0, '0, '0, rasr_pkg::KIND_OTHER));
		add_word(mk(rasr_pkg::CMD_RESTORE, 1'b0, 1'b0, '0, '0, rasr_pkg::KIND_OTHER));
		add_word(mk(rasr_pkg::CMD_LOG, 1'b0, 1'b0, '0, 5'd31, rasr_pkg::KIND_ICALL));
		add_word(mk(rasr_pkg::CMD_LOG, 1'b0, 1'b0, '0, 5'd3, rasr_pkg::KIND_OTHER));
		add_word(mk(rasr_pkg::CMD_MISP, 1'b0, 1'b0, '0, 5'd0, rasr_pkg::KIND_OTHER));
		add_word(mk(rasr_pkg::CMD_FLUSH, 1'b0, 1'b0, '0, 5'd31, rasr_pkg::KIND_OTHER));
		add_word(mk(rasr_pkg::CMD_MISP, 1'b1, 1'b1, '1, 5'd1, rasr_pkg::KIND_RET));
		add_word(mk(CMD_UNUSED6, 1'b0, 1'b0, '0, '0, rasr_pkg::KIND_OTHER));
		add_word(mk(CMD_UNUSED7, 1'b1, 1'b1, '1, '1, rasr_pkg::KIND_RET));
		wait_drained();

		for (int k = 0; k < 9; k++) begin
			if (k < 3) begin
				send_idle = 24;
				rcv_idle = 86;
			end else if (k < 6) begin
				send_idle = 86;
				rcv_idle = 24;
			end else begin
				send_idle = 0;
				rcv_idle = 0;
			end
			program_mode(phase_modes[k]);
			if (k == 6)
				hold_asked++;
			if (k == 3) begin
				add_random_words(46, phase_modes[k]);
				wait_drained();
				add_random_words(46, phase_modes[k]);
			end else begin
				add_random_words(92, phase_modes[k]);
			end
			wait_drained();
		end

		repeat (100) @(posedge clk);
		$display("Covered %0d command words, %0d of them stack recoveries, in all four modes.",
			words_in, recoveries);
		$display("Checked %0d result words, %0d with the check flag raised.",
			results_out, flagged);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
